/* src/multi_voice_adsr_envelope_top_assert.svh */
// Assertion macros used by the checker file.
`ifndef MULTI_VOICE_ADSR_ENVELOPE_TOP_ASSERT_SVH
`define MULTI_VOICE_ADSR_ENVELOPE_TOP_ASSERT_SVH
// Implication checked at every rising clock edge outside reset.
`define MVA_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define MVA_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`endif

/* src/mvadsr_pkg.sv */
// ----------------------------------------------------------------------------
// mvadsr_pkg
// Shared types and constants of the multi-voice envelope generator.
// ----------------------------------------------------------------------------
package mvadsr_pkg;
   localparam int VOICES = 6;
   localparam int VOICE_W = 3;
   localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam logic [15:0] ONE_Q15 = 16'h8000;

   localparam logic [2:0] REG_ATTACK = 3'd0;
   localparam logic [2:0] REG_DECAY = 3'd1;
   localparam logic [2:0] REG_SUSTAIN = 3'd2;
   localparam logic [2:0] REG_RELEASE = 3'd3;
   localparam logic [2:0] REG_INTENSITY = 3'd4;

   // Per-voice state word held in the voice memory.
   typedef struct packed {
      logic [31:0] note_start;
      logic [31:0] rel_start;
      logic        rel_run;
      logic [15:0] att;
      logic [15:0] dec;
      logic [15:0] sus;
      logic [15:0] sv_att;
      logic [15:0] sv_dec;
      logic [15:0] sv_sus;
      logic        last_on;
      logic        last_rel;
   } voice_state_type;

   function automatic voice_state_type reset_state();
      voice_state_type s;
      s.note_start = '0;
      s.rel_start = '0;
      s.rel_run = 1'b0;
      s.att = ONE_Q15;
      s.dec = ONE_Q15;
      s.sus = ONE_Q15;
      s.sv_att = ONE_Q15;
      s.sv_dec = ONE_Q15;
      s.sv_sus = ONE_Q15;
      s.last_on = 1'b0;
      s.last_rel = 1'b0;
      return s;
   endfunction
endpackage

/* src/mvadsr_if.sv */
// ----------------------------------------------------------------------------
// mvadsr_req_if / mvadsr_rsp_if / mvadsr_csr_if
// Valid/ready channels of the envelope generator.
// ----------------------------------------------------------------------------
interface mvadsr_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  voice;
   logic [31:0] now_ms;
   logic        note_on;
   logic        releasing;
   modport source (output valid, voice, now_ms, note_on, releasing, input ready);
   modport sink (input valid, voice, now_ms, note_on, releasing, output ready);
endinterface

interface mvadsr_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  voice_out;
   logic [15:0] envelope_coefficient;
   modport source (output valid, voice_out, envelope_coefficient, input ready);
   modport sink (input valid, voice_out, envelope_coefficient, output ready);
endinterface

interface mvadsr_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [16:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* src/multi_voice_adsr_envelope_top.sv */
// ----------------------------------------------------------------------------
// multi_voice_adsr_envelope_top
// Per-voice ADSR filter-envelope coefficient generator, state kept in memory.
// ----------------------------------------------------------------------------
// Steps from the accepting edge to a valid result: state read, edge update,
// at most one 48-step division and its hand-off, three multiply steps and the
// blend; a bad voice sets the result valid at the accepting edge itself.
// Flow: one item at a time; a new item can be accepted once the result of the
// previous item has been taken from the output register.
// Reset: synchronous, active high; a clearing pass then rewrites every voice
// entry with its neutral state before items are taken.
module multi_voice_adsr_envelope_top (
   input logic clock,
   input logic reset,
   mvadsr_req_if.sink   req,
   mvadsr_rsp_if.source rsp,
   mvadsr_csr_if.sink   csr
);
   // Controller steps; ST_CLEAR runs only after reset and an item may skip ST_DIV2.
   typedef enum logic [9:0] {
      ST_CLEAR = 10'b0000000001,
      ST_IDLE  = 10'b0000000010,
      ST_READ  = 10'b0000000100,
      ST_EDGE  = 10'b0000001000,
      ST_DIV1  = 10'b0000010000,
      ST_DIV2  = 10'b0000100000,
      ST_MUL1  = 10'b0001000000,
      ST_MUL2  = 10'b0010000000,
      ST_MUL3  = 10'b0100000000,
      ST_OUT   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [15:0] attack_ff, decay_ff, sustain_ff, release_ff;
   logic [16:0] intensity_ff;

   // Voice memory: one entry per voice, read into a register.
   mvadsr_pkg::voice_state_type mem [mvadsr_pkg::VOICES];
   mvadsr_pkg::voice_state_type rd_ff;
   logic [mvadsr_pkg::VIDX_W-1:0] waddr;
   logic                          wen;
   mvadsr_pkg::voice_state_type   wdata;
   logic [mvadsr_pkg::VIDX_W-1:0] clr_ff, clr_in;

   // Item registers.
   logic [2:0]  voice_ff;
   logic [31:0] now_ff;
   logic        on_ff, rel_ff;
   mvadsr_pkg::voice_state_type st_ff, st_in;
   logic [31:0] elapsed_ff, elapsed_in;
   logic        div_phase_ff, div_phase_in;
   logic [15:0] prod_ff, prod_in;
   logic [15:0] relc_ff, relc_in;
   logic        rsp_valid_ff;
   logic [2:0]  rsp_voice_ff;
   logic [15:0] rsp_coef_ff;

   logic        div_start, div_done;
   logic [47:0] div_dividend, div_quotient;
   logic [15:0] div_divisor;

   logic [15:0] sus_sat;
   logic [16:0] ad_sum;
   logic [31:0] dec_span;
   logic [31:0] mul_prod;
   logic [15:0] mul_a, mul_b;
   logic        in_range;

   assign sus_sat = (sustain_ff > mvadsr_pkg::ONE_Q15) ? mvadsr_pkg::ONE_Q15 : sustain_ff;
   assign ad_sum = {1'b0, attack_ff} + {1'b0, decay_ff};
   // Time into the decay ramp; below the decay duration whenever it is used.
   assign dec_span = elapsed_ff - {16'd0, attack_ff};
   assign in_range = ({29'd0, req.voice} < 32'(mvadsr_pkg::VOICES));

   assign csr.ready = 1'b1;
   assign req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.voice_out = rsp_voice_ff;
   assign rsp.envelope_coefficient = rsp_coef_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_ff <= '0;
         decay_ff <= '0;
         sustain_ff <= mvadsr_pkg::ONE_Q15;
         release_ff <= '0;
         intensity_ff <= '0;
      end else if (csr.valid) begin
         unique case (csr.index)
            mvadsr_pkg::REG_ATTACK: attack_ff <= csr.data[15:0];
            mvadsr_pkg::REG_DECAY: decay_ff <= csr.data[15:0];
            mvadsr_pkg::REG_SUSTAIN: sustain_ff <= csr.data[15:0];
            mvadsr_pkg::REG_RELEASE: release_ff <= csr.data[15:0];
            mvadsr_pkg::REG_INTENSITY: intensity_ff <= csr.data;
            default: ;
         endcase
      end
   end

   mvadsr_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dividend),
      .divisor(div_divisor), .done(div_done), .quotient(div_quotient)
   );

   // Intensity clamp and magnitude.
   logic        f_neg;
   logic [15:0] f_mag;
   logic [16:0] f_neg_mag;
   always_comb begin
      f_neg = intensity_ff[16];
      f_neg_mag = 17'(-intensity_ff);
      if (f_neg) f_mag = (f_neg_mag > 17'h08000) ? mvadsr_pkg::ONE_Q15
                                                 : f_neg_mag[15:0];
      else f_mag = (intensity_ff[15:0] > mvadsr_pkg::ONE_Q15) ? mvadsr_pkg::ONE_Q15
                                                             : intensity_ff[15:0];
   end

   assign mul_prod = mul_a * mul_b;

   always_comb begin
      state_in = state_ff;
      st_in = st_ff;
      clr_in = clr_ff;
      elapsed_in = elapsed_ff;
      div_phase_in = div_phase_ff;
      prod_in = prod_ff;
      relc_in = relc_ff;
      wen = 1'b0;
      waddr = voice_ff[mvadsr_pkg::VIDX_W-1:0];
      wdata = st_ff;
      div_start = 1'b0;
      div_dividend = '0;
      div_divisor = 16'd1;
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            wen = 1'b1;
            waddr = clr_ff;
            wdata = mvadsr_pkg::reset_state();
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == 32'(mvadsr_pkg::VOICES - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req.valid && req.ready && in_range) state_in = ST_READ;
         end
         ST_READ: state_in = ST_EDGE;
         ST_EDGE: begin
            st_in = rd_ff;
            if (on_ff && !rd_ff.last_on) begin
               st_in.note_start = now_ff;
               st_in.rel_run = 1'b0;
               st_in.att = '0;
               st_in.dec = mvadsr_pkg::ONE_Q15;
               st_in.sus = mvadsr_pkg::ONE_Q15;
            end
            if (rel_ff && !rd_ff.last_rel) begin
               st_in.rel_start = now_ff;
               st_in.rel_run = 1'b1;
               st_in.sv_att = st_in.att;
               st_in.sv_dec = st_in.dec;
               st_in.sv_sus = st_in.sus;
            end
            elapsed_in = on_ff ? now_ff - st_in.note_start : now_ff - st_in.rel_start;
            relc_in = mvadsr_pkg::ONE_Q15;
            div_phase_in = 1'b0;
            state_in = ST_DIV1;
         end
         ST_DIV1: begin
            // Decide which division this step needs, if any.
            if (on_ff) begin
               st_in.rel_run = 1'b0;
               if (!div_phase_ff) begin
                  if (attack_ff != 0 && elapsed_ff < {16'd0, attack_ff}) begin
                     div_start = 1'b1;
                     div_dividend = {1'b0, elapsed_ff, 15'd0};
                     div_divisor = attack_ff;
                     state_in = ST_DIV2;
                  end else begin
                     st_in.att = mvadsr_pkg::ONE_Q15;
                     div_phase_in = 1'b1;
                  end
               end else begin
                  if (decay_ff != 0 && elapsed_ff > {16'd0, attack_ff}
                      && {1'b0, elapsed_ff} < {16'd0, ad_sum}) begin
                     div_start = 1'b1;
                     div_dividend = {16'd0, {16'd0, dec_span[15:0]}
                                    * {16'd0, mvadsr_pkg::ONE_Q15 - sus_sat}};
                     div_divisor = decay_ff;
                     state_in = ST_DIV2;
                  end else begin
                     st_in.dec = mvadsr_pkg::ONE_Q15;
                     state_in = ST_MUL1;
                  end
                  if ((decay_ff != 0 && {1'b0, elapsed_ff} >= {16'd0, ad_sum})
                      || (decay_ff == 0 && elapsed_ff >= {16'd0, attack_ff}))
                     st_in.sus = sus_sat;
                  else
                     st_in.sus = mvadsr_pkg::ONE_Q15;
               end
            end else if (!st_ff.rel_run) begin
               st_in.att = mvadsr_pkg::ONE_Q15;
               st_in.dec = mvadsr_pkg::ONE_Q15;
               st_in.sus = mvadsr_pkg::ONE_Q15;
               state_in = ST_MUL1;
            end else begin
               st_in.att = st_ff.sv_att;
               st_in.dec = st_ff.sv_dec;
               st_in.sus = st_ff.sv_sus;
               if (release_ff != 0 && elapsed_ff < {16'd0, release_ff}) begin
                  div_start = 1'b1;
                  div_dividend = {1'b0, elapsed_ff, 15'd0};
                  div_divisor = release_ff;
                  state_in = ST_DIV2;
               end else begin
                  relc_in = '0;
                  state_in = ST_MUL1;
               end
            end
         end
         ST_DIV2: begin
            if (div_done) begin
               if (on_ff && !div_phase_ff) begin
                  st_in.att = div_quotient[15:0];
                  div_phase_in = 1'b1;
                  state_in = ST_DIV1;
               end else if (on_ff) begin
                  st_in.dec = mvadsr_pkg::ONE_Q15 - div_quotient[15:0];
                  state_in = ST_MUL1;
               end else begin
                  relc_in = mvadsr_pkg::ONE_Q15 - div_quotient[15:0];
                  state_in = ST_MUL1;
               end
            end
         end
         ST_MUL1: begin
            mul_a = st_ff.att;
            mul_b = st_ff.dec;
            prod_in = mul_prod[30:15];
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            mul_a = prod_ff;
            mul_b = st_ff.sus;
            prod_in = mul_prod[30:15];
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            mul_a = prod_ff;
            mul_b = relc_ff;
            prod_in = mul_prod[30:15];
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // Blend, then write back the voice entry.
            mul_a = f_mag;
            mul_b = f_neg ? prod_ff : mvadsr_pkg::ONE_Q15 - prod_ff;
            prod_in = mvadsr_pkg::ONE_Q15 - mul_prod[30:15];
            wdata = st_ff;
            if (st_ff.rel_run && !rel_ff) begin
               wdata.rel_run = 1'b0;
               wdata.sv_att = mvadsr_pkg::ONE_Q15;
               wdata.sv_dec = mvadsr_pkg::ONE_Q15;
               wdata.sv_sus = mvadsr_pkg::ONE_Q15;
               wdata.att = mvadsr_pkg::ONE_Q15;
               wdata.dec = mvadsr_pkg::ONE_Q15;
               wdata.sus = mvadsr_pkg::ONE_Q15;
               prod_in = mvadsr_pkg::ONE_Q15;
            end
            wdata.last_on = on_ff;
            wdata.last_rel = rel_ff;
            wen = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wen) mem[waddr] <= wdata;
      if (state_ff == ST_READ) rd_ff <= mem[voice_ff[mvadsr_pkg::VIDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         div_phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         div_phase_ff <= div_phase_in;
         if (state_ff == ST_OUT) rsp_valid_ff <= 1'b1;
         else if (req.valid && req.ready && !in_range) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
      end
      st_ff <= st_in;
      elapsed_ff <= elapsed_in;
      prod_ff <= prod_in;
      relc_ff <= relc_in;
      if (req.valid && req.ready) begin
         voice_ff <= req.voice;
         now_ff <= req.now_ms;
         on_ff <= req.note_on;
         rel_ff <= req.releasing;
         rsp_voice_ff <= req.voice;
         rsp_coef_ff <= mvadsr_pkg::ONE_Q15;
      end
      if (state_ff == ST_OUT) rsp_coef_ff <= prod_in;
   end
endmodule

/* src/mvadsr_div.sv */
// ----------------------------------------------------------------------------
// mvadsr_div
// Restoring divider, one quotient bit per cycle, 48-bit by 16-bit.
// ----------------------------------------------------------------------------
module mvadsr_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [47:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [47:0] quotient
);
   logic [47:0] quo_ff, quo_in;
   logic [16:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [15:0] dsr_ff, dsr_in;
   logic [16:0] trial;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      dsr_in = dsr_ff;
      trial = {rem_ff[15:0], quo_ff[47]};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = 6'd0;
         busy_in = 1'b1;
         dsr_in = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quo_in = {quo_ff[46:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd47) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;
endmodule

/* src/mvadsr_checker.sv */
// ----------------------------------------------------------------------------
// mvadsr_checker
// Port-level checks of the envelope generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "multi_voice_adsr_envelope_top_assert.svh"
module mvadsr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_coef
);
   // The coefficient never exceeds one.
   `MVA_ASSERT_IMPLY(a_coef_range, clock, reset, rsp_valid, rsp_coef <= 16'h8000)
   // A waiting result is held until taken.
   `MVA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // No new item is taken while a result waits.
   `MVA_ASSERT_IMPLY(a_one_item, clock, reset, rsp_valid, !req_ready)
   // An accepted item leaves the input closed next cycle.
   `MVA_ASSERT_NEXT(a_busy, clock, reset, req_valid && req_ready, !req_ready)
endmodule

bind multi_voice_adsr_envelope_top mvadsr_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_coef(rsp.envelope_coefficient)
);

/* tb/sv/multi_voice_adsr_envelope_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_voice_adsr_envelope_top_tb
// Drives voice updates and register writes into the envelope generator and
// checks every coefficient against a cycle-free envelope predictor or a typed-in value.
// ----------------------------------------------------------------------------
module multi_voice_adsr_envelope_top_tb;
   // A register index the block does not decode; writes to it must be ignored.
   localparam logic [2:0] REG_SPARE = 3'd7;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int SETTLE_CYCLES = 120;
   localparam int PHASES = 10;
   localparam int ITEMS_PER_PHASE = 190;
   localparam int N_DIRECTED = 33;
   localparam int NO_GOLDEN = -1;

   typedef struct packed {
      logic [2:0]  voice;
      logic [15:0] coef;
   } coef_item_t;

   // One row of the directed table: either a register write or a voice update.
   typedef struct {
      bit          is_csr;
      logic [2:0]  sel;
      logic [31:0] value;
      bit          on;
      bit          rel;
      int          golden;
   } stim_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mvadsr_req_if req_ch ();
   mvadsr_rsp_if rsp_ch ();
   mvadsr_csr_if csr_ch ();

   multi_voice_adsr_envelope_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Envelope predictor state: a private copy of the registers and voices.
   logic [15:0] p_attack_ms, p_decay_ms, p_sustain, p_release_ms;
   int          p_intensity;
   logic [31:0] p_note_start [mvadsr_pkg::VOICES];
   logic [31:0] p_rel_start  [mvadsr_pkg::VOICES];
   bit          p_rel_run    [mvadsr_pkg::VOICES];
   logic [15:0] p_att [mvadsr_pkg::VOICES], p_dec [mvadsr_pkg::VOICES];
   logic [15:0] p_sus [mvadsr_pkg::VOICES], p_rls [mvadsr_pkg::VOICES];
   logic [15:0] p_sv_att [mvadsr_pkg::VOICES], p_sv_dec [mvadsr_pkg::VOICES];
   logic [15:0] p_sv_sus [mvadsr_pkg::VOICES];
   bit          p_last_on [mvadsr_pkg::VOICES], p_last_rel [mvadsr_pkg::VOICES];

   coef_item_t  pending_coefs [$];
   int          mismatches = 0;
   longint      cycles = 0;

   // Per-voice stimulus sequencer.
   logic [31:0] seq_time [mvadsr_pkg::VOICES];
   int          seq_state [mvadsr_pkg::VOICES];
   int          seq_count [mvadsr_pkg::VOICES];

   stim_row_t directed_rows [N_DIRECTED] = '{
      '{1'b0, 3'd0, 32'd50, 1'b0, 1'b0, 32768},
      '{1'b0, 3'd7, 32'd0, 1'b1, 1'b1, 32768},
      '{1'b1, mvadsr_pkg::REG_ATTACK, 32'd10, 1'b0, 1'b0, NO_GOLDEN},
      '{1'b1, mvadsr_pkg::REG_DECAY, 32'd10, 1'b0, 1'b0, NO_GOLDEN},
      '{1'b1, mvadsr_pkg::REG_SUSTAIN, 32'd16384, 1'b0, 1'b0, NO_GOLDEN},
      '{1'b1, mvadsr_pkg::REG_RELEASE, 32'd10, 1'b0, 1'b0, NO_GOLDEN},
      '{1'b1, mvadsr_pkg::REG_INTENSITY, 32'd32768, 1'b0, 1'b0, NO_GOLDEN},
      '{1'b0, 3'd0, 32'd100, 1'b1, 1'b0, 0},
      '{1'b0, 3'd0, 32'd105, 1'b1, 1'b0, NO_GOLDEN},
      '{1'b0, 3'd0, 32'd115, 1'b1, 1'b0, NO_GOLDEN},
      '{1'b0, 3'd0, 32'd130, 1'b1, 1'b0, NO_GOLDEN},
      '{1'b0, 3'd0, 32'd131, 1'b0, 1'b1, NO_GOLDEN},
      '{1'b0, 3'd0, 32'd136, 1'b0, 1'b1, NO_GOLDEN},
      '{1'b0, 3'd0, 32'd145, 1'b0, 1'b1, 0},
      '{1'b0, 3'd0, 32'd146, 1'b0, 1'b0, 32768},
      '{1'b0, 3'd6, 32'hFFFF_FFFF, 1'b1, 1'b0, 32768},
      '{1'b1, mvadsr_pkg::REG_INTENSITY, 32'h1_FFFF, 1'b0, 1'b0, NO_GOLDEN},
      '{1'b1, REG_SPARE, 32'h1_2345, 1'b0, 1'b0, NO_GOLDEN},
      '{1'b0, 3'd1, 32'hFFFF_FFF8, 1'b1, 1'b0, NO_GOLDEN},
      '{1'b0, 3'd1, 32'd2, 1'b1, 1'b0, NO_GOLDEN},
      '{1'b0, 3'd1, 32'd3, 1'b1, 1'b1, NO_GOLDEN},
      '{1'b0, 3'd1, 32'd4, 1'b0, 1'b1, NO_GOLDEN},
      '{1'b1, mvadsr_pkg::REG_SUSTAIN, 32'hFFFF, 1'b0, 1'b0, NO_GOLDEN},
      '{1'b1, mvadsr_pkg::REG_INTENSITY, 32'h1_0000, 1'b0, 1'b0, NO_GOLDEN},
      '{1'b0, 3'd2, 32'd200, 1'b1, 1'b0, NO_GOLDEN},
      '{1'b0, 3'd2, 32'd300, 1'b1, 1'b0, NO_GOLDEN},
      '{1'b1, mvadsr_pkg::REG_ATTACK, 32'hFFFF, 1'b0, 1'b0, NO_GOLDEN},
      '{1'b1, mvadsr_pkg::REG_DECAY, 32'hFFFF, 1'b0, 1'b0, NO_GOLDEN},
      '{1'b1, mvadsr_pkg::REG_RELEASE, 32'hFFFF, 1'b0, 1'b0, NO_GOLDEN},
      '{1'b0, 3'd3, 32'd0, 1'b1, 1'b0, NO_GOLDEN},
      '{1'b0, 3'd3, 32'h0000_FFFF, 1'b1, 1'b0, NO_GOLDEN},
      '{1'b0, 3'd3, 32'h0001_2345, 1'b0, 1'b1, NO_GOLDEN},
      '{1'b0, 3'd3, 32'h0002_0000, 1'b0, 1'b0, 32768}
   };

   function automatic logic [31:0] q15_mul(logic [31:0] x, logic [31:0] y);
      longint unsigned p;
      p = longint'(x) * longint'(y);
      return 32'(p >> 15);
   endfunction

   task automatic predictor_reset();
      p_attack_ms = '0;
      p_decay_ms = '0;
      p_sustain = mvadsr_pkg::ONE_Q15;
      p_release_ms = '0;
      p_intensity = 0;
      for (int v = 0; v < mvadsr_pkg::VOICES; v++) begin
         p_note_start[v] = '0;
         p_rel_start[v] = '0;
         p_rel_run[v] = 1'b0;
         p_att[v] = mvadsr_pkg::ONE_Q15;
         p_dec[v] = mvadsr_pkg::ONE_Q15;
         p_sus[v] = mvadsr_pkg::ONE_Q15;
         p_rls[v] = mvadsr_pkg::ONE_Q15;
         p_sv_att[v] = mvadsr_pkg::ONE_Q15;
         p_sv_dec[v] = mvadsr_pkg::ONE_Q15;
         p_sv_sus[v] = mvadsr_pkg::ONE_Q15;
         p_last_on[v] = 1'b0;
         p_last_rel[v] = 1'b0;
      end
   endtask

   task automatic predictor_write(logic [2:0] idx, logic [16:0] data);
      case (idx)
         mvadsr_pkg::REG_ATTACK: p_attack_ms = data[15:0];
         mvadsr_pkg::REG_DECAY: p_decay_ms = data[15:0];
         mvadsr_pkg::REG_SUSTAIN: p_sustain = data[15:0];
         mvadsr_pkg::REG_RELEASE: p_release_ms = data[15:0];
         mvadsr_pkg::REG_INTENSITY: p_intensity = int'($signed(data));
         default: ;
      endcase
   endtask

   // Works out the coefficient of one voice update and advances that voice.
   function automatic logic [15:0] predict_envelope(logic [2:0] vin, logic [31:0] now,
                                                    bit on, bit rel);
      longint unsigned e, r, ad, sus, one;
      logic [31:0] raw, target, res, mag;
      int f, v;
      one = 32768;
      if (vin >= mvadsr_pkg::VOICES) return mvadsr_pkg::ONE_Q15;
      v = int'(vin);
      sus = (p_sustain > mvadsr_pkg::ONE_Q15) ? one : longint'(p_sustain);
      if (on && !p_last_on[v]) begin
         p_note_start[v] = now;
         p_rel_run[v] = 1'b0;
         p_att[v] = '0;
         p_dec[v] = mvadsr_pkg::ONE_Q15;
         p_sus[v] = mvadsr_pkg::ONE_Q15;
         p_rls[v] = mvadsr_pkg::ONE_Q15;
      end
      if (rel && !p_last_rel[v]) begin
         p_rel_start[v] = now;
         p_rel_run[v] = 1'b1;
         p_sv_att[v] = p_att[v];
         p_sv_dec[v] = p_dec[v];
         p_sv_sus[v] = p_sus[v];
      end
      if (on) begin
         e = longint'(32'(now - p_note_start[v]));
         ad = longint'(p_attack_ms) + longint'(p_decay_ms);
         p_rel_run[v] = 1'b0;
         if (p_attack_ms > 0 && e < p_attack_ms)
            p_att[v] = 16'((e * one) / p_attack_ms);
         else
            p_att[v] = mvadsr_pkg::ONE_Q15;
         if (p_decay_ms > 0 && e > p_attack_ms && e < ad)
            p_dec[v] = 16'(one - ((e - p_attack_ms) * (one - sus)) / p_decay_ms);
         else
            p_dec[v] = mvadsr_pkg::ONE_Q15;
         if ((p_decay_ms > 0 && e >= ad) || (p_decay_ms == 0 && e >= p_attack_ms))
            p_sus[v] = 16'(sus);
         else
            p_sus[v] = mvadsr_pkg::ONE_Q15;
         p_rls[v] = mvadsr_pkg::ONE_Q15;
      end else if (!p_rel_run[v]) begin
         p_att[v] = mvadsr_pkg::ONE_Q15;
         p_dec[v] = mvadsr_pkg::ONE_Q15;
         p_sus[v] = mvadsr_pkg::ONE_Q15;
         p_rls[v] = mvadsr_pkg::ONE_Q15;
      end else begin
         r = longint'(32'(now - p_rel_start[v]));
         if (p_release_ms > 0 && r < p_release_ms)
            p_rls[v] = 16'(one - (r * one) / p_release_ms);
         else
            p_rls[v] = '0;
         p_att[v] = p_sv_att[v];
         p_dec[v] = p_sv_dec[v];
         p_sus[v] = p_sv_sus[v];
      end
      raw = q15_mul(q15_mul(q15_mul(32'(p_att[v]), 32'(p_dec[v])), 32'(p_sus[v])),
                    32'(p_rls[v]));
      f = p_intensity;
      if (f > 32768) f = 32768;
      if (f < -32768) f = -32768;
      mag = 32'((f < 0) ? -f : f);
      target = (f >= 0) ? raw : 32'd32768 - raw;
      res = 32'd32768 - q15_mul(mag, 32'd32768 - target);
      if (p_rel_run[v] && !rel) begin
         p_rel_run[v] = 1'b0;
         p_sv_att[v] = mvadsr_pkg::ONE_Q15;
         p_sv_dec[v] = mvadsr_pkg::ONE_Q15;
         p_sv_sus[v] = mvadsr_pkg::ONE_Q15;
         p_att[v] = mvadsr_pkg::ONE_Q15;
         p_dec[v] = mvadsr_pkg::ONE_Q15;
         p_sus[v] = mvadsr_pkg::ONE_Q15;
         p_rls[v] = mvadsr_pkg::ONE_Q15;
         res = 32'd32768;
      end
      p_last_on[v] = on;
      p_last_rel[v] = rel;
      return res[15:0];
   endfunction

   // Idle lengths: mostly none, often short, now and then a long pause.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Sends one voice update. The expectation is queued at the accepting edge,
   // taken from the typed-in value where the table supplies one.
   task automatic send_update(logic [2:0] voice, logic [31:0] now, bit on, bit rel,
                              int golden);
      coef_item_t exp_item;
      int gap;
      @(negedge clock);
      req_ch.valid = 1'b1;
      req_ch.voice = voice;
      req_ch.now_ms = now;
      req_ch.note_on = on;
      req_ch.releasing = rel;
      do @(posedge clock); while (!req_ch.ready);
      exp_item.voice = voice;
      exp_item.coef = predict_envelope(voice, now, on, rel);
      if (golden != NO_GOLDEN) exp_item.coef = 16'(golden);
      pending_coefs.push_back(exp_item);
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Registers only change while the block is idle: every coefficient must
   // be back and the pipeline given time to settle before the write.
   task automatic write_register(logic [2:0] idx, logic [16:0] data);
      @(negedge clock);
      req_ch.valid = 1'b0;
      wait (pending_coefs.size() == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data = data;
      do @(posedge clock); while (!csr_ch.ready);
      predictor_write(idx, data);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   function automatic logic [16:0] pick_duration();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return 17'($urandom_range(0, 65535));
      return 17'($urandom_range(1, 40));
   endfunction

   task automatic configure_phase(int phase);
      logic [16:0] sus;
      if (phase == 0) begin
         write_register(mvadsr_pkg::REG_ATTACK, '0);
         write_register(mvadsr_pkg::REG_DECAY, '0);
         write_register(mvadsr_pkg::REG_SUSTAIN, '0);
         write_register(mvadsr_pkg::REG_RELEASE, '0);
         write_register(mvadsr_pkg::REG_INTENSITY, 17'h1_8000);
      end else if (phase == 1) begin
         write_register(mvadsr_pkg::REG_ATTACK, 17'hFFFF);
         write_register(mvadsr_pkg::REG_DECAY, 17'hFFFF);
         write_register(mvadsr_pkg::REG_SUSTAIN, 17'h8000);
         write_register(mvadsr_pkg::REG_RELEASE, 17'hFFFF);
         write_register(mvadsr_pkg::REG_INTENSITY, 17'h0_8000);
      end else begin
         write_register(mvadsr_pkg::REG_ATTACK, pick_duration());
         write_register(mvadsr_pkg::REG_DECAY, pick_duration());
         sus = ($urandom_range(0, 4) == 0) ? 17'($urandom_range(0, 65535))
                                           : 17'($urandom_range(0, 32768));
         write_register(mvadsr_pkg::REG_SUSTAIN, sus);
         write_register(mvadsr_pkg::REG_RELEASE, pick_duration());
         write_register(mvadsr_pkg::REG_INTENSITY, 17'($urandom_range(0, 131071)));
         if ($urandom_range(0, 2) == 0)
            write_register(3'($urandom_range(5, 7)), 17'($urandom_range(0, 131071)));
      end
   endtask

   // Builds the next random update: mostly well-formed note/release sequences
   // per voice, with some voices out of range and some flag noise.
   task automatic random_update();
      logic [2:0] voice;
      logic [31:0] now;
      bit on, rel;
      int v;
      if ($urandom_range(0, 19) == 0) begin
         send_update(3'($urandom_range(6, 7)), $urandom, 1'($urandom), 1'($urandom),
                     NO_GOLDEN);
         return;
      end
      v = $urandom_range(0, mvadsr_pkg::VOICES - 1);
      voice = 3'(v);
      if ($urandom_range(0, 29) == 0)
         seq_time[v] = $urandom;
      else
         seq_time[v] = seq_time[v] + $urandom_range(0, 9);
      now = seq_time[v];
      on = 1'b0;
      rel = 1'b0;
      case (seq_state[v])
         0: begin
            if (--seq_count[v] <= 0) begin
               seq_state[v] = 1;
               seq_count[v] = $urandom_range(1, 15);
            end
         end
         1: begin
            on = 1'b1;
            rel = ($urandom_range(0, 19) == 0);
            if (--seq_count[v] <= 0) begin
               seq_state[v] = 2;
               seq_count[v] = $urandom_range(1, 15);
            end
         end
         default: begin
            rel = 1'b1;
            if (--seq_count[v] <= 0) begin
               seq_state[v] = 0;
               seq_count[v] = $urandom_range(1, 4);
            end
         end
      endcase
      if ($urandom_range(0, 9) == 0) begin
         on = 1'($urandom);
         rel = 1'($urandom);
      end
      send_update(voice, now, on, rel, NO_GOLDEN);
   endtask

   // Result side: the sink stalls in random bursts.
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         rsp_ch.ready = 1'b1;
         repeat ($urandom_range(1, 20)) @(negedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   end

   // Every accepted coefficient is compared with the oldest expectation.
   always @(posedge clock) begin
      coef_item_t want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_coefs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected coefficient: voice %0d coef %0d",
                        rsp_ch.voice_out, rsp_ch.envelope_coefficient);
         end else begin
            want = pending_coefs.pop_front();
            if (rsp_ch.voice_out !== want.voice ||
                rsp_ch.envelope_coefficient !== want.coef) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected voice %0d coef %0d, got voice %0d coef %0d",
                           want.voice, want.coef, rsp_ch.voice_out,
                           rsp_ch.envelope_coefficient);
            end
         end
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.voice = '0;
      req_ch.now_ms = '0;
      req_ch.note_on = 1'b0;
      req_ch.releasing = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      predictor_reset();
      for (int v = 0; v < mvadsr_pkg::VOICES; v++) begin
         seq_time[v] = $urandom;
         seq_state[v] = 0;
         seq_count[v] = $urandom_range(1, 4);
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table: reset state, a full attack-decay-sustain-release
      // cycle, time wrap, saturation and clamping, ignored writes.
      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr)
            write_register(directed_rows[i].sel, directed_rows[i].value[16:0]);
         else
            send_update(directed_rows[i].sel, directed_rows[i].value,
                        directed_rows[i].on, directed_rows[i].rel,
                        directed_rows[i].golden);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         configure_phase(ph);
         repeat (ITEMS_PER_PHASE) random_update();
      end

      @(negedge clock);
      req_ch.valid = 1'b0;
      wait (pending_coefs.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_coefs.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule

/* files.f */
+incdir+src
src/mvadsr_pkg.sv
src/mvadsr_if.sv
src/mvadsr_div.sv
src/multi_voice_adsr_envelope_top.sv
src/mvadsr_checker.sv
tb/sv/multi_voice_adsr_envelope_top_tb.sv
